[hw/rtl/skt_pkg.sv]
// Shared types and constants for the sorted key table.
// Holds the table geometry, the request action codes and the result status codes.
// No dependencies.
package skt_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int ACT_W    = 3;
  localparam int POS_W    = 7;
  localparam int STAT_W   = 3;
  localparam int RIDX_W   = 7;
  localparam int ECNT_W   = 7;

  typedef enum logic [ACT_W-1:0] {
    ACT_FIND          = 3'd0,
    ACT_INSERT_SORTED = 3'd1,
    ACT_INSERT_AT     = 3'd2,
    ACT_REMOVE_AT     = 3'd3,
    ACT_REMOVE_KEY    = 3'd4,
    ACT_INDEX_OF      = 3'd5
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK          = 3'd0,
    ST_NOT_FOUND   = 3'd1,
    ST_FULL        = 3'd2,
    ST_BAD_INDEX   = 3'd3,
    ST_NEED_SORTED = 3'd4
  } status_t;

endpackage

[hw/rtl/skt_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing; used for the key storage of the sorted key table.
module skt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read; data appears in the cycle after the address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[hw/rtl/sorted_key_table_top.sv]
// Sorted key table: request sequencer around one key memory.
// Depends on skt_pkg and skt_ram.
//
// Usage
//   Requests arrive as beats on the in_ stream; each gives exactly one result beat on the
//   out_ stream. The sorted_mode register is written through the cfg_ channel, which is
//   always ready; write it only while no request is in flight.
//   One request is handled at a time: in_tready is high while the sequencer is idle.
//   All keys live in one single-port-read, single-port-write RAM with a registered read,
//   and that port sets the timing: a find or remove_key search reads and compares the
//   middle entry once per halving step, an insert shift moves entries up one at a time
//   before the key is written, a remove shift moves entries down one at a time, and an
//   index_of scan reads the entries in order until it finds a match. Around these come
//   the accept of the request and the load of the result register.
//   The result register decouples the sides: the next request is taken while a result
//   still waits, and the sequencer holds its finished result while the receiver stalls.
//   Reset clears the entry count, sets sorted mode and empties the result register; the
//   key memory is not cleared, as only entries below the count are ever read.
module sorted_key_table_top
  import skt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Request stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [2:0] action, [34:3] key, [41:35] position, rest zero
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [2:0] status, [9:3] result_index, [16:10] entry_count
  // Configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data    // sorted_mode
);

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SHUP,
    S_SHDN,
    S_SCAN,
    S_RESP
  } state_t;

  state_t             state_r, state_nxt;
  logic [ACT_W-1:0]   act_r, act_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               mode_r, mode_nxt;
  logic [CNT_W-1:0]   lo_r, lo_nxt;
  logic [CNT_W-1:0]   hi_r, hi_nxt;
  logic [CNT_W-1:0]   mid_r, mid_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   ptr_r, ptr_nxt;
  logic               pend_r, pend_nxt;
  logic [CNT_W-1:0]   paddr_r, paddr_nxt;
  logic [STAT_W-1:0]  stat_r, stat_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [23:0]        out_data_r, out_data_nxt;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_wa;
  logic [KEY_W-1:0]   ram_wd;
  logic [IDX_W-1:0]   ram_ra;
  logic [KEY_W-1:0]   ram_rd;

  logic [ACT_W-1:0]   in_act;
  logic [KEY_W-1:0]   in_key;
  logic [POS_W-1:0]   in_pos;
  logic [CNT_W:0]     mid_sum;
  logic [CNT_W-1:0]   mid_calc;
  logic               res_load;

  assign in_act   = in_tdata[2:0];
  assign in_key   = in_tdata[34:3];
  assign in_pos   = in_tdata[41:35];
  assign mid_sum  = {1'b0, lo_r} + {1'b0, hi_r} - {{CNT_W{1'b0}}, 1'b1};
  assign mid_calc = mid_sum[CNT_W:1];
  assign res_load = (state_r == S_RESP) && (!out_valid_r || out_tready);

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  skt_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CAPACITY)
  ) u_keys (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_addr (ram_ra),
    .rd_data (ram_rd)
  );

  // Request sequencer: search, shift, scan and result hand-off.
  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    key_nxt       = key_r;
    count_nxt     = count_r;
    mode_nxt      = mode_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    idx_nxt       = idx_r;
    ptr_nxt       = ptr_r;
    pend_nxt      = pend_r;
    paddr_nxt     = paddr_r;
    stat_nxt      = stat_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_wa        = paddr_r[IDX_W-1:0];
    ram_wd        = ram_rd;
    ram_ra        = '0;

    if (cfg_valid) begin
      mode_nxt = cfg_data;
    end
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          act_nxt  = in_act;
          key_nxt  = in_key;
          lo_nxt   = '0;
          hi_nxt   = count_r;
          idx_nxt  = '0;
          pend_nxt = 1'b0;
          stat_nxt = ST_BAD_INDEX;
          state_nxt = S_RESP;
          case (in_act) inside
            ACT_FIND, ACT_REMOVE_KEY: begin
              if (!mode_r) begin
                stat_nxt = ST_NEED_SORTED;
              end else begin
                state_nxt = S_SRCH_RD;
              end
            end
            ACT_INSERT_SORTED: begin
              if (count_r >= CAP_CNT) begin
                stat_nxt = ST_FULL;
              end else if (mode_r) begin
                state_nxt = S_SRCH_RD;
              end else begin
                idx_nxt   = count_r;
                ptr_nxt   = count_r;
                state_nxt = S_SHUP;
              end
            end
            ACT_INSERT_AT: begin
              if (CNT_W'(in_pos) > count_r) begin
                stat_nxt = ST_BAD_INDEX;
              end else if (count_r >= CAP_CNT) begin
                stat_nxt = ST_FULL;
              end else begin
                idx_nxt   = CNT_W'(in_pos);
                ptr_nxt   = count_r;
                state_nxt = S_SHUP;
              end
            end
            ACT_REMOVE_AT: begin
              if (CNT_W'(in_pos) >= count_r) begin
                stat_nxt = ST_BAD_INDEX;
              end else begin
                idx_nxt   = CNT_W'(in_pos);
                ptr_nxt   = CNT_W'(in_pos);
                state_nxt = S_SHDN;
              end
            end
            ACT_INDEX_OF: begin
              ptr_nxt   = '0;
              state_nxt = S_SCAN;
            end
            default: begin
              stat_nxt = ST_BAD_INDEX;
            end
          endcase
        end
      end

      // Issue the read of the middle entry, or finish with the insertion point.
      S_SRCH_RD: begin
        if (lo_r < hi_r) begin
          ram_ra    = mid_calc[IDX_W-1:0];
          mid_nxt   = mid_calc;
          state_nxt = S_SRCH_CMP;
        end else begin
          idx_nxt = lo_r;
          case (act_r)
            ACT_INSERT_SORTED: begin
              ptr_nxt   = count_r;
              state_nxt = S_SHUP;
            end
            default: begin
              stat_nxt  = ST_NOT_FOUND;
              state_nxt = S_RESP;
            end
          endcase
        end
      end

      // Compare the middle entry and narrow the range.
      S_SRCH_CMP: begin
        if (ram_rd == key_r) begin
          idx_nxt = mid_r;
          case (act_r)
            ACT_INSERT_SORTED: begin
              ptr_nxt   = count_r;
              state_nxt = S_SHUP;
            end
            ACT_REMOVE_KEY: begin
              ptr_nxt   = mid_r;
              state_nxt = S_SHDN;
            end
            default: begin
              stat_nxt  = ST_OK;
              state_nxt = S_RESP;
            end
          endcase
        end else begin
          if (ram_rd < key_r) begin
            lo_nxt = mid_r + 1'b1;
          end else begin
            hi_nxt = mid_r;
          end
          state_nxt = S_SRCH_RD;
        end
      end

      // Move entries up from the top down to the insert index, then write the key.
      S_SHUP: begin
        pend_nxt = 1'b0;
        if (pend_r) begin
          ram_we = 1'b1;
        end
        if (ptr_r > idx_r) begin
          ram_ra    = IDX_W'(ptr_r - 1'b1);
          pend_nxt  = 1'b1;
          paddr_nxt = ptr_r;
          ptr_nxt   = ptr_r - 1'b1;
        end else if (!pend_r) begin
          ram_we    = 1'b1;
          ram_wa    = idx_r[IDX_W-1:0];
          ram_wd    = key_r;
          count_nxt = count_r + 1'b1;
          stat_nxt  = ST_OK;
          state_nxt = S_RESP;
        end
      end

      // Move entries down from the removed index to the top.
      S_SHDN: begin
        pend_nxt = 1'b0;
        if (pend_r) begin
          ram_we = 1'b1;
        end
        if ((ptr_r + 1'b1) < count_r) begin
          ram_ra    = IDX_W'(ptr_r + 1'b1);
          pend_nxt  = 1'b1;
          paddr_nxt = ptr_r;
          ptr_nxt   = ptr_r + 1'b1;
        end else if (!pend_r) begin
          count_nxt = count_r - 1'b1;
          stat_nxt  = ST_OK;
          state_nxt = S_RESP;
        end
      end

      // Linear scan: one read per cycle, compare in the cycle after it.
      S_SCAN: begin
        pend_nxt = 1'b0;
        if (pend_r && (ram_rd == key_r)) begin
          idx_nxt   = paddr_r;
          stat_nxt  = ST_OK;
          state_nxt = S_RESP;
        end else if (ptr_r < count_r) begin
          ram_ra    = ptr_r[IDX_W-1:0];
          pend_nxt  = 1'b1;
          paddr_nxt = ptr_r;
          ptr_nxt   = ptr_r + 1'b1;
        end else begin
          stat_nxt  = ST_NOT_FOUND;
          state_nxt = S_RESP;
        end
      end

      // Load the result register once it is free.
      S_RESP: begin
        if (res_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {7'd0, ECNT_W'(count_r), RIDX_W'(idx_r), stat_r};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      mode_r      <= 1'b1;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      mode_r      <= mode_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    act_r      <= act_nxt;
    key_r      <= key_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    idx_r      <= idx_nxt;
    ptr_r      <= ptr_nxt;
    paddr_r    <= paddr_nxt;
    stat_r     <= stat_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_CNT)
    else $error("entry count exceeds capacity");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_SHUP || state_r == S_SHDN))
    else $error("key memory written outside a shift");

  a_count_moves_in_shift: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && count_r != $past(count_r))
      |-> ($past(state_r) == S_SHUP || $past(state_r) == S_SHDN))
    else $error("entry count changed outside a shift");

  a_full_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    (res_load && stat_r == ST_FULL) |-> count_r == CAP_CNT)
    else $error("table full reported below capacity");
`endif

endmodule

[dv/testbench.sv]
// Self-checking testbench for sorted_key_table_top: drives request beats and checks
// every result beat against a cycle-free model of the table kept in this file.
// Depends on skt_pkg and the sorted_key_table_top RTL.
module testbench;
  import skt_pkg::*;

  // Action codes that the block does not define; they must come back as bad index.
  localparam logic [ACT_W-1:0] ACT_UNDEFINED_LO = 3'd6;
  localparam logic [ACT_W-1:0] ACT_UNDEFINED_HI = 3'd7;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    status_t     status;
    logic [6:0]  idx;
    logic [6:0]  cnt;
  } table_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // [2:0] action, [34:3] key, [41:35] position, rest zero
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // [2:0] status, [9:3] result_index, [16:10] entry_count
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;   // sorted_mode

  // Model of the table contents, its fill level and the mode register.
  logic [KEY_W-1:0] model_keys [CAPACITY];
  int               model_count;
  bit               model_sorted;

  table_result_t awaited_results[$];
  int            mismatches;
  int            rx_hold_cycles;
  bit            quiet;

  sorted_key_table_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // Clock with a period of two time units.
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Binary search over the occupied entries; slot is the match or the insertion point.
  function automatic bit search_keys(input logic [KEY_W-1:0] key, output int slot);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = model_count - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (model_keys[mid] == key) begin
        slot = mid;
        return 1'b1;
      end
      if (model_keys[mid] < key) lo = mid + 1;
      else hi = mid - 1;
    end
    slot = lo;
    return 1'b0;
  endfunction

  function automatic void insert_key(input int slot, input logic [KEY_W-1:0] key);
    for (int i = model_count; i > slot; i--) model_keys[i] = model_keys[i-1];
    model_keys[slot] = key;
    model_count++;
  endfunction

  function automatic void remove_key(input int slot);
    for (int i = slot; i + 1 < model_count; i++) model_keys[i] = model_keys[i+1];
    model_count--;
  endfunction

  // Applies one request to the model and returns the result the block must give.
  function automatic table_result_t apply_request(input logic [ACT_W-1:0] act,
                                                  input logic [KEY_W-1:0] key,
                                                  input logic [POS_W-1:0] pos);
    table_result_t r;
    int            slot;
    bit            hit;
    r.status = ST_BAD_INDEX;
    r.idx    = '0;
    slot     = 0;
    case (act)
      ACT_FIND: begin
        if (!model_sorted) begin
          r.status = ST_NEED_SORTED;
        end else begin
          hit      = search_keys(key, slot);
          r.status = hit ? ST_OK : ST_NOT_FOUND;
          r.idx    = slot[6:0];
        end
      end
      ACT_INSERT_SORTED: begin
        if (model_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          if (model_sorted) hit = search_keys(key, slot);
          else slot = model_count;
          insert_key(slot, key);
          r.status = ST_OK;
          r.idx    = slot[6:0];
        end
      end
      ACT_INSERT_AT: begin
        if (int'(pos) > model_count) begin
          r.status = ST_BAD_INDEX;
        end else if (model_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          insert_key(int'(pos), key);
          r.status = ST_OK;
          r.idx    = pos;
        end
      end
      ACT_REMOVE_AT: begin
        if (int'(pos) >= model_count) begin
          r.status = ST_BAD_INDEX;
        end else begin
          remove_key(int'(pos));
          r.status = ST_OK;
          r.idx    = pos;
        end
      end
      ACT_REMOVE_KEY: begin
        if (!model_sorted) begin
          r.status = ST_NEED_SORTED;
        end else if (search_keys(key, slot)) begin
          remove_key(slot);
          r.status = ST_OK;
          r.idx    = slot[6:0];
        end else begin
          r.status = ST_NOT_FOUND;
          r.idx    = slot[6:0];
        end
      end
      ACT_INDEX_OF: begin
        r.status = ST_NOT_FOUND;
        for (int i = 0; i < model_count; i++) begin
          if (model_keys[i] == key) begin
            r.status = ST_OK;
            r.idx    = i[6:0];
            break;
          end
        end
      end
      default: r.status = ST_BAD_INDEX;
    endcase
    r.cnt = model_count[6:0];
    return r;
  endfunction

  // Offers one request beat, with an occasional idle burst first, and records the
  // expected result once the beat is taken.
  task automatic send_request(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] key,
                              input logic [POS_W-1:0] pos);
    int gap;
    gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, pos, key, act};
    do @(posedge clk); while (!in_tready);
    awaited_results.push_back(apply_request(act, key, pos));
  endtask

  // Stops offering requests and waits until every result has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  // Writes the sorted_mode register while no request is in flight.
  task automatic write_sorted_mode(input bit mode);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk); while (!cfg_ready);
    model_sorted = mode;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Keys come mostly from a small pool or from the table itself, so that searches hit.
  function automatic logic [KEY_W-1:0] pick_key();
    int s;
    s = $urandom_range(0, 9);
    if (s < 4) return $urandom_range(0, 40);
    if (s < 7 && model_count > 0) return model_keys[$urandom_range(0, model_count - 1)];
    if (s == 7) return 32'hFFFF_FFFF - $urandom_range(0, 3);
    return $urandom();
  endfunction

  // One random request; in sorted mode most positional inserts keep the order intact.
  task automatic send_random_request();
    logic [ACT_W-1:0] act;
    logic [KEY_W-1:0] key;
    logic [POS_W-1:0] pos;
    int               r;
    int               slot;
    bit               hit;
    r   = $urandom_range(0, 99);
    key = pick_key();
    if (model_count >= 56 && r < 40) r = 45;
    if (r < 30) act = ACT_INSERT_SORTED;
    else if (r < 40) act = ACT_INSERT_AT;
    else if (r < 55) act = ACT_REMOVE_AT;
    else if (r < 70) act = ACT_REMOVE_KEY;
    else if (r < 85) act = ACT_FIND;
    else if (r < 97) act = ACT_INDEX_OF;
    else act = $urandom_range(0, 1) ? ACT_UNDEFINED_LO : ACT_UNDEFINED_HI;
    pos = POS_W'($urandom_range(0, 127));
    if (act == ACT_INSERT_AT && $urandom_range(0, 9) != 0) begin
      if (model_sorted && $urandom_range(0, 4) != 0) begin
        hit = search_keys(key, slot);
        pos = slot[6:0];
      end else begin
        pos = POS_W'($urandom_range(0, model_count));
      end
    end else if (act == ACT_REMOVE_AT && model_count > 0 && $urandom_range(0, 9) != 0) begin
      pos = POS_W'($urandom_range(0, model_count - 1));
    end
    send_request(act, key, pos);
  endtask

  // Result checker: each result beat is compared with the oldest expectation.
  always @(posedge clk) begin
    table_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("tb: result beat with nothing expected: status %0d index %0d count %0d",
                   out_tdata[2:0], out_tdata[9:3], out_tdata[16:10]);
      end else begin
        exp_r = awaited_results.pop_front();
        if (out_tdata[2:0] !== exp_r.status || out_tdata[9:3] !== exp_r.idx ||
            out_tdata[16:10] !== exp_r.cnt) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("tb: mismatch: expected status %0d index %0d count %0d, got %0d %0d %0d",
                     exp_r.status, exp_r.idx, exp_r.cnt,
                     out_tdata[2:0], out_tdata[9:3], out_tdata[16:10]);
        end
      end
    end
  end

  // Receiver: random stall bursts, plus a long hold-off counted down here on request.
  initial begin
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        out_tready <= 1'b0;
        rx_hold_cycles--;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        out_tready <= 1'b0;
        stall_left = $urandom_range(0, 3);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Edge values of every field, each action on an empty and a small table, and the
  // undefined action codes.
  task automatic test_directed_edges();
    send_request(ACT_FIND, 32'd5, 7'd0);
    send_request(ACT_REMOVE_AT, 32'd0, 7'd0);
    send_request(ACT_REMOVE_KEY, 32'd5, 7'd0);
    send_request(ACT_INDEX_OF, 32'd5, 7'd0);
    send_request(ACT_INSERT_AT, 32'd9, 7'd1);
    send_request(ACT_INSERT_SORTED, 32'hFFFF_FFFF, 7'd0);
    send_request(ACT_INSERT_SORTED, 32'd0, 7'd0);
    send_request(ACT_INSERT_SORTED, 32'd0, 7'd0);
    send_request(ACT_INSERT_SORTED, 32'h8000_0000, 7'd0);
    send_request(ACT_FIND, 32'd0, 7'd0);
    send_request(ACT_FIND, 32'hFFFF_FFFF, 7'd0);
    send_request(ACT_FIND, 32'd5, 7'd0);
    send_request(ACT_INSERT_AT, 32'hFFFF_FFFF, 7'd4);
    send_request(ACT_INSERT_AT, 32'd0, 7'd0);
    send_request(ACT_REMOVE_AT, 32'd0, 7'd6);
    send_request(ACT_REMOVE_AT, 32'd0, 7'd0);
    send_request(ACT_REMOVE_KEY, 32'hFFFF_FFFF, 7'd0);
    send_request(ACT_REMOVE_KEY, 32'd7, 7'd0);
    send_request(ACT_INDEX_OF, 32'd0, 7'd0);
    send_request(ACT_INDEX_OF, 32'h5555_AAAA, 7'd0);
    send_request(ACT_UNDEFINED_LO, 32'd0, 7'd0);
    send_request(ACT_UNDEFINED_HI, 32'hFFFF_FFFF, 7'h7F);
    send_request(ACT_INSERT_AT, 32'd3, 7'h7F);
    send_request(ACT_REMOVE_AT, 32'd3, 7'd64);
  endtask

  // Fills the table to capacity, probes the full cases, then empties most of it.
  task automatic test_fill_to_capacity();
    while (model_count < CAPACITY) send_request(ACT_INSERT_SORTED, pick_key(), 7'd0);
    send_request(ACT_INSERT_SORTED, 32'd1, 7'd0);
    send_request(ACT_INSERT_AT, 32'd1, 7'd64);
    send_request(ACT_INSERT_AT, 32'd1, 7'd65);
    send_request(ACT_FIND, model_keys[CAPACITY-1], 7'd0);
    send_request(ACT_INDEX_OF, model_keys[CAPACITY-1], 7'd0);
    send_request(ACT_REMOVE_AT, 32'd0, 7'd64);
    send_request(ACT_REMOVE_AT, 32'd0, 7'd63);
    send_request(ACT_INSERT_SORTED, 32'h7FFF_FFFF, 7'd0);
    send_request(ACT_REMOVE_KEY, model_keys[0], 7'd0);
    while (model_count > 8) begin
      if ($urandom_range(0, 1))
        send_request(ACT_REMOVE_AT, 32'd0, POS_W'($urandom_range(0, model_count - 1)));
      else send_request(ACT_REMOVE_KEY, model_keys[$urandom_range(0, model_count - 1)], 7'd0);
    end
  endtask

  task automatic test_random_traffic(input int n);
    repeat (n) send_random_request();
  endtask

  // Unsorted mode: searches are refused and sorted inserts append. The table is
  // emptied before sorted mode comes back so that later searches see ordered keys.
  task automatic test_unsorted_mode();
    write_sorted_mode(1'b0);
    send_request(ACT_FIND, 32'd1, 7'd0);
    send_request(ACT_REMOVE_KEY, 32'd1, 7'd0);
    send_request(ACT_INSERT_SORTED, 32'd0, 7'd0);
    send_request(ACT_INDEX_OF, 32'd0, 7'd0);
    test_random_traffic(100);
    while (model_count > 0)
      send_request(ACT_REMOVE_AT, $urandom(), POS_W'($urandom_range(0, model_count - 1)));
    write_sorted_mode(1'b1);
  endtask

  // The receiver holds off while requests keep coming, so the block backs up; then
  // the sender waits for every result before going on.
  task automatic test_output_backpressure();
    rx_hold_cycles = 300;
    repeat (12) send_random_request();
    wait_drained();
  endtask

  // Last stretch with no idling on either side.
  task automatic test_quiet_tail();
    quiet = 1'b1;
    test_random_traffic(60);
  endtask

  // Run limit.
  initial begin
    #1_000_000;
    $display("tb: failure");
    $finish;
  end

  // Main sequence.
  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    cfg_valid      = 1'b0;
    cfg_data       = 1'b0;
    mismatches     = 0;
    rx_hold_cycles = 0;
    quiet          = 1'b0;
    model_count    = 0;
    model_sorted   = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_edges();
    test_fill_to_capacity();
    test_random_traffic(300);
    test_unsorted_mode();
    test_random_traffic(100);
    test_output_backpressure();
    test_quiet_tail();

    wait_drained();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/skt_pkg.sv
hw/rtl/skt_ram.sv
hw/rtl/sorted_key_table_top.sv
dv/testbench.sv
